### hw/rtl/lsda_call_site_parser_top_assert.svh
// assertion macros for the call-site parser
`ifndef LSDA_CALL_SITE_PARSER_TOP_ASSERT_SVH
`define LSDA_CALL_SITE_PARSER_TOP_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define LSDA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("lsda assertion failed");

// next-cycle implication
`define LSDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lsda assertion failed");

`else

`define LSDA_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define LSDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/lsda_pkg.sv
package lsda_pkg;

	// payload bits per uleb128 byte
	localparam int ULEB_BITS = 7;
	// shift group count saturates here (shift of 70 bits)
	localparam int GRP_SAT = (64 + ULEB_BITS - 1) / ULEB_BITS;
	localparam int GRP_W = 4;

	// front to back queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam int LEN_W = 32;

	// one classified input item
	typedef struct packed {
		logic       start;      // restart parsing with this byte
		logic       uleb_last;  // continuation bit clear
		logic [7:0] data;
	} item_t;

endpackage

### hw/rtl/lsda_front.sv
`include "lsda_call_site_parser_top_assert.svh"

module lsda_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           data_byte,
	input  logic                 start_flag,
	output logic                 q_valid,
	output lsda_pkg::item_t      q_item,
	input  logic                 q_pop
);

	lsda_pkg::item_t                   mem_q [lsda_pkg::QDEPTH];
	logic [lsda_pkg::QPTR_W-1:0]       wr_q;
	logic [lsda_pkg::QPTR_W-1:0]       rd_q;
	logic [lsda_pkg::QCNT_W-1:0]       count_q;
	logic                              push;
	lsda_pkg::item_t                   cls;

	// classify the byte on the way in
	always_comb begin
		cls.start     = start_flag;
		cls.uleb_last = ~data_byte[7];
		cls.data      = data_byte;
	end

	assign in_stall = (count_q == lsda_pkg::QCNT_W'(lsda_pkg::QDEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + lsda_pkg::QPTR_W'(1);
			end
			if (q_pop) begin
				rd_q <= rd_q + lsda_pkg::QPTR_W'(1);
			end
			if (push && !q_pop) begin
				count_q <= count_q + lsda_pkg::QCNT_W'(1);
			end else if (!push && q_pop) begin
				count_q <= count_q - lsda_pkg::QCNT_W'(1);
			end
		end
	end

	`LSDA_ASSERT_NOW(a_pop_not_empty, clk, arst_n, q_pop, count_q != '0)
	`LSDA_ASSERT_NEXT(a_fill_step, clk, arst_n, push && !q_pop,
		count_q == $past(count_q) + lsda_pkg::QCNT_W'(1))

endmodule

### hw/rtl/lsda_back.sv
`include "lsda_call_site_parser_top_assert.svh"

module lsda_back #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  lsda_pkg::item_t      q_item,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 record_kind,
	output logic [7:0]           first_encoding,
	output logic [7:0]           second_encoding,
	output logic [63:0]          header_offset,
	output logic [7:0]           third_encoding,
	output logic [31:0]          table_length,
	output logic [63:0]          site_start,
	output logic [63:0]          site_end,
	output logic [63:0]          handler_addr,
	output logic [7:0]           action_byte,
	output logic                 last_site,
	output logic                 error_code
);

	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_ENC2   = 4'd1;
	localparam logic [3:0] PH_OFFSET = 4'd2;
	localparam logic [3:0] PH_ENC3   = 4'd3;
	localparam logic [3:0] PH_TABLEN = 4'd4;
	localparam logic [3:0] PH_START  = 4'd5;
	localparam logic [3:0] PH_END    = 4'd6;
	localparam logic [3:0] PH_LPAD   = 4'd7;
	localparam logic [3:0] PH_ACTION = 4'd8;
	localparam logic [3:0] PH_DONE   = 4'd9;

	localparam int GW = lsda_pkg::GRP_W;
	localparam int LW = lsda_pkg::LEN_W;

	typedef struct packed {
		logic                   kind;
		logic [7:0]             enc1;
		logic [7:0]             enc2;
		logic [VALUE_WIDTH-1:0] hoff;
		logic [7:0]             enc3;
		logic [LW-1:0]          tlen;
		logic [VALUE_WIDTH-1:0] sstart;
		logic [VALUE_WIDTH-1:0] send;
		logic [VALUE_WIDTH-1:0] lpad;
		logic [7:0]             action;
		logic                   last;
		logic                   err;
	} res_t;

	// parser state
	logic [3:0]             phase_q, phase_d;
	logic [VALUE_WIDTH-1:0] acc_q, acc_d;
	logic [GW-1:0]          grp_q, grp_d;
	logic [LW-1:0]          left_q, left_d;
	logic [7:0]             enc1_q, enc1_d;
	logic [7:0]             enc2_q, enc2_d;
	logic [7:0]             enc3_q, enc3_d;
	logic [VALUE_WIDTH-1:0] hoff_q, hoff_d;
	logic [VALUE_WIDTH-1:0] sstart_q, sstart_d;
	logic [VALUE_WIDTH-1:0] send_q, send_d;
	logic [VALUE_WIDTH-1:0] lpad_q, lpad_d;

	// output register
	logic                   valid_q;
	res_t                   res_q;
	res_t                   res_d;
	logic                   emit;

	logic [VALUE_WIDTH-1:0] chunk;
	logic [VALUE_WIDTH-1:0] acc_fed;
	logic [GW-1:0]          grp_fed;
	logic [63:0]            len_full;
	logic [LW-1:0]          len_sat;
	logic [LW-1:0]          left_dec;
	logic                   vdone;

	// seven payload bits land at the current group position
	for (genvar i = 0; i < VALUE_WIDTH; i++) begin : g_chunk
		assign chunk[i] = (grp_q == GW'(i / lsda_pkg::ULEB_BITS))
			&& q_item.data[i % lsda_pkg::ULEB_BITS];
	end

	assign acc_fed  = acc_q | chunk;
	assign grp_fed  = (grp_q == GW'(lsda_pkg::GRP_SAT)) ? grp_q : grp_q + GW'(1);
	assign vdone    = q_item.uleb_last;
	assign len_full = 64'(acc_fed);
	assign len_sat  = (|len_full[63:LW]) ? '1 : len_full[LW-1:0];
	assign left_dec = left_q - LW'(1);

	assign q_pop = q_valid && (!valid_q || !out_stall);

	always_comb begin
		phase_d  = phase_q;
		acc_d    = acc_q;
		grp_d    = grp_q;
		left_d   = left_q;
		enc1_d   = enc1_q;
		enc2_d   = enc2_q;
		enc3_d   = enc3_q;
		hoff_d   = hoff_q;
		sstart_d = sstart_q;
		send_d   = send_q;
		lpad_d   = lpad_q;
		emit     = 1'b0;
		res_d    = '0;

		if (q_item.start) begin
			phase_d = PH_ENC2;
			acc_d   = '0;
			grp_d   = '0;
			left_d  = '0;
			enc1_d  = q_item.data;
		end else begin
			unique case (phase_q)
				PH_ENC2: begin
					enc2_d  = q_item.data;
					phase_d = PH_OFFSET;
				end
				PH_OFFSET: begin
					acc_d = acc_fed;
					grp_d = grp_fed;
					if (vdone) begin
						hoff_d  = acc_fed;
						acc_d   = '0;
						grp_d   = '0;
						phase_d = PH_ENC3;
					end
				end
				PH_ENC3: begin
					enc3_d  = q_item.data;
					phase_d = PH_TABLEN;
				end
				PH_TABLEN: begin
					acc_d = acc_fed;
					grp_d = grp_fed;
					if (vdone) begin
						acc_d      = '0;
						grp_d      = '0;
						left_d     = len_sat;
						sstart_d   = '0;
						send_d     = '0;
						lpad_d     = '0;
						emit       = 1'b1;
						res_d.kind = 1'b0;
						res_d.enc1 = enc1_q;
						res_d.enc2 = enc2_q;
						res_d.hoff = hoff_q;
						res_d.enc3 = enc3_q;
						res_d.tlen = len_sat;
						res_d.last = (len_sat == '0);
						phase_d    = (len_sat == '0) ? PH_DONE : PH_START;
					end
				end
				PH_START, PH_END, PH_LPAD: begin
					left_d = left_dec;
					acc_d  = acc_fed;
					grp_d  = grp_fed;
					if (vdone) begin
						acc_d = '0;
						grp_d = '0;
						if (phase_q == PH_START) begin
							sstart_d = acc_fed;
							phase_d  = PH_END;
						end else if (phase_q == PH_END) begin
							send_d  = acc_fed;
							phase_d = PH_LPAD;
						end else begin
							lpad_d  = acc_fed;
							phase_d = PH_ACTION;
						end
					end
					// table ran out inside the entry
					if (left_dec == '0) begin
						emit         = 1'b1;
						res_d.kind   = 1'b1;
						res_d.sstart = sstart_d;
						res_d.send   = send_d;
						res_d.lpad   = lpad_d;
						res_d.last   = 1'b1;
						res_d.err    = 1'b1;
						acc_d        = '0;
						grp_d        = '0;
						phase_d      = PH_DONE;
					end
				end
				PH_ACTION: begin
					left_d       = left_dec;
					emit         = 1'b1;
					res_d.kind   = 1'b1;
					res_d.sstart = sstart_q;
					res_d.send   = send_q;
					res_d.lpad   = lpad_q;
					res_d.action = q_item.data;
					res_d.last   = (left_dec == '0);
					sstart_d     = '0;
					send_d       = '0;
					lpad_d       = '0;
					phase_d      = (left_dec == '0) ? PH_DONE : PH_START;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			grp_q   <= '0;
			left_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				grp_q   <= grp_d;
				left_q  <= left_d;
			end
			if (q_pop && emit) begin
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			enc1_q   <= enc1_d;
			enc2_q   <= enc2_d;
			enc3_q   <= enc3_d;
			hoff_q   <= hoff_d;
			sstart_q <= sstart_d;
			send_q   <= send_d;
			lpad_q   <= lpad_d;
		end
		if (q_pop && emit) begin
			res_q <= res_d;
		end
	end

	assign out_valid       = valid_q;
	assign record_kind     = res_q.kind;
	assign first_encoding  = res_q.enc1;
	assign second_encoding = res_q.enc2;
	assign header_offset   = 64'(res_q.hoff);
	assign third_encoding  = res_q.enc3;
	assign table_length    = res_q.tlen;
	assign site_start      = 64'(res_q.sstart);
	assign site_end        = 64'(res_q.send);
	assign handler_addr    = 64'(res_q.lpad);
	assign action_byte     = res_q.action;
	assign last_site       = res_q.last;
	assign error_code      = res_q.err;

	`LSDA_ASSERT_NOW(a_table_left, clk, arst_n,
		phase_q == PH_START || phase_q == PH_END || phase_q == PH_LPAD || phase_q == PH_ACTION,
		left_q != '0)
	`LSDA_ASSERT_NOW(a_done_clean, clk, arst_n, phase_q == PH_DONE, acc_q == '0)

endmodule

### hw/rtl/lsda_call_site_parser_top.sv
// call-site table parser: one data-area byte per item, one record per header or entry
// throughput: one item per cycle, one parser step per byte, except while out_stall holds a record
// path: an accepted byte enters the 4-deep queue; if none is queued ahead and the output
//   register is free or draining, the parser pops it and registers its result, offered until taken
// reset: arst_n clears the queue, parser phase and output valid at once; no clearing pass

module lsda_call_site_parser_top #(
	// decoded uleb128 values keep this many low bits (16 to 64)
	parameter int VALUE_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,

	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        start_flag,

	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        record_kind,
	output logic [7:0]  first_encoding,
	output logic [7:0]  second_encoding,
	output logic [63:0] header_offset,
	output logic [7:0]  third_encoding,
	output logic [31:0] table_length,
	output logic [63:0] site_start,
	output logic [63:0] site_end,
	output logic [63:0] handler_addr,
	output logic [7:0]  action_byte,
	output logic        last_site,
	output logic        error_code
);

	// queue between the front and the parser
	logic            q_valid;
	logic            q_pop;
	lsda_pkg::item_t q_item;

	// front: takes bytes, tags start and uleb end, queues them
	// in_stall rises only when the queue is full
	lsda_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.start_flag (start_flag),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	// back: header and call-site state machine plus output register
	// pops a byte whenever the output register is free or being drained;
	// a record held by the receiver stops parsing until it is taken,
	// while the queue keeps absorbing input bytes
	lsda_back #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_item          (q_item),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.record_kind     (record_kind),
		.first_encoding  (first_encoding),
		.second_encoding (second_encoding),
		.header_offset   (header_offset),
		.third_encoding  (third_encoding),
		.table_length    (table_length),
		.site_start      (site_start),
		.site_end        (site_end),
		.handler_addr    (handler_addr),
		.action_byte     (action_byte),
		.last_site       (last_site),
		.error_code      (error_code)
	);

endmodule
